### rtl/core/utd_pkg.sv
package utd_pkg;

  // result codes
  typedef enum logic [2:0] {
    ST_LABEL   = 3'd0,
    ST_BEGIN   = 3'd1,
    ST_END     = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_BAD_LEN = 3'd4,
    ST_BAD_UTF = 3'd5,
    ST_VOCAB   = 3'd6
  } status_t;

  // per-token decode state
  typedef struct packed {
    logic [2:0]  count;
    logic [7:0]  lead;
    logic [20:0] cp;
    logic        cont_ok;
    logic        m_begin;
    logic        m_end;
    logic        m_unk;
  } token_state_t;

  localparam token_state_t TOKEN_CLEAR = '{
    count: 3'd0, lead: 8'h00, cp: 21'd0,
    cont_ok: 1'b1, m_begin: 1'b1, m_end: 1'b1, m_unk: 1'b1
  };

  localparam logic [2:0]  COUNT_MAX  = 3'd7;
  localparam logic [2:0]  LEN_BEGIN  = 3'd3;
  localparam logic [2:0]  LEN_END    = 3'd4;
  localparam logic [2:0]  LEN_UNK    = 3'd5;
  localparam logic [2:0]  CONT_LIMIT = 3'd4;
  localparam logic [20:0] CP_MAX     = 21'h10ffff;
  localparam logic [20:0] SURR_LO    = 21'h00d800;
  localparam logic [20:0] SURR_HI    = 21'h00dfff;
  localparam logic [20:0] MIN_CP2    = 21'h000080;
  localparam logic [20:0] MIN_CP3    = 21'h000800;
  localparam logic [20:0] MIN_CP4    = 21'd65536;
  localparam logic [21:0] LABEL_BASE = 22'd100;
  localparam logic [11:0] VOCAB_RESET = 12'd4093;

  // utf-8 sequence length from the lead byte, zero when not a valid lead
  function automatic logic [2:0] lead_size(input logic [7:0] b);
    logic [2:0] s;
    if (b < 8'h80) s = 3'd1;
    else if (b >= 8'hc2 && b < 8'he0) s = 3'd2;
    else if (b >= 8'he0 && b < 8'hf0) s = 3'd3;
    else if (b >= 8'hf0 && b <= 8'hf4) s = 3'd4;
    else s = 3'd0;
    return s;
  endfunction

  // "<s>"
  function automatic logic begin_at(input logic [2:0] pos, input logic [7:0] b);
    logic r;
    case (pos)
      3'd0: r = (b == 8'h3c);
      3'd1: r = (b == 8'h73);
      3'd2: r = (b == 8'h3e);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // "</s>"
  function automatic logic end_at(input logic [2:0] pos, input logic [7:0] b);
    logic r;
    case (pos)
      3'd0: r = (b == 8'h3c);
      3'd1: r = (b == 8'h2f);
      3'd2: r = (b == 8'h73);
      3'd3: r = (b == 8'h3e);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // "<unk>"
  function automatic logic unk_at(input logic [2:0] pos, input logic [7:0] b);
    logic r;
    case (pos)
      3'd0: r = (b == 8'h3c);
      3'd1: r = (b == 8'h75);
      3'd2: r = (b == 8'h6e);
      3'd3: r = (b == 8'h6b);
      3'd4: r = (b == 8'h3e);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/utd_token_state.sv
module utd_token_state import utd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   byte_in,
  input  logic         last_in,
  output token_state_t cur,
  output token_state_t upd
);

  token_state_t st;
  logic [2:0]   size0;

  // fold one byte into the token state
  always_comb begin
    upd = st;
    size0 = lead_size(byte_in);
    upd.m_begin = st.m_begin && begin_at(st.count, byte_in);
    upd.m_end   = st.m_end && end_at(st.count, byte_in);
    upd.m_unk   = st.m_unk && unk_at(st.count, byte_in);
    if (st.count == 3'd0) begin
      upd.lead = byte_in;
      case (size0)
        3'd1: upd.cp = {14'd0, byte_in[6:0]};
        3'd2: upd.cp = {16'd0, byte_in[4:0]};
        3'd3: upd.cp = {17'd0, byte_in[3:0]};
        3'd4: upd.cp = {18'd0, byte_in[2:0]};
        default: upd.cp = 21'd0;
      endcase
    end else if (st.count < CONT_LIMIT) begin
      if (byte_in[7:6] != 2'b10) upd.cont_ok = 1'b0;
      upd.cp = {st.cp[14:0], byte_in[5:0]};
    end
    upd.count = (st.count < COUNT_MAX) ? st.count + 3'd1 : COUNT_MAX;
  end

  // state register, cleared after each token
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= TOKEN_CLEAR;
    end else if (step) begin
      st <= last_in ? TOKEN_CLEAR : upd;
    end
  end

  assign cur = st;

endmodule

### rtl/core/utd_classify.sv
module utd_classify import utd_pkg::*; (
  input  token_state_t tok,
  input  logic [11:0]  vocab,
  output status_t      status_out,
  output logic [11:0]  label_out
);

  logic [2:0]  size;
  logic [21:0] diff;
  logic        bad_utf;
  logic        out_vocab;

  // code point checks
  always_comb begin
    size = lead_size(tok.lead);
    diff = {1'b0, tok.cp} - LABEL_BASE;
    bad_utf = !tok.cont_ok ||
              (size == 3'd2 && tok.cp < MIN_CP2) ||
              (size == 3'd3 && tok.cp < MIN_CP3) ||
              (size == 3'd4 && tok.cp < MIN_CP4) ||
              (tok.cp > CP_MAX) ||
              (tok.cp >= SURR_LO && tok.cp <= SURR_HI);
    out_vocab = diff[21] || (diff[20:0] >= {9'd0, vocab});
  end

  // priority of marks and errors
  always_comb begin
    label_out = 12'd0;
    if (tok.m_begin && tok.count == LEN_BEGIN) begin
      status_out = ST_BEGIN;
    end else if (tok.m_end && tok.count == LEN_END) begin
      status_out = ST_END;
    end else if (tok.m_unk && tok.count == LEN_UNK) begin
      status_out = ST_UNKNOWN;
    end else if (size == 3'd0 || tok.count != size) begin
      status_out = ST_BAD_LEN;
    end else if (bad_utf) begin
      status_out = ST_BAD_UTF;
    end else if (out_vocab) begin
      status_out = ST_VOCAB;
    end else begin
      status_out = ST_LABEL;
      label_out = diff[11:0];
    end
  end

endmodule

### rtl/core/utd_token_id_decoder.sv
// Token id decoder: takes one byte of a token per item, last_byte set on the
// final byte, and gives one result per token: a begin, end or unknown mark for
// "<s>", "</s>" and "<unk>", an error code, or the label (code point - 100,
// below the vocabulary size). One byte is accepted every cycle while in_stall is
// low; a byte is held in the input register while the decode state and the
// result are worked out, and the result is registered from there.
// in_stall rises only when a last byte waits in the input register behind a
// result that is still stalled. vocab_limit is to be written through the cfg
// port only while idle (the block does not enforce this); it resets to 4093.
module utf8_token_id_decoder import utd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [11:0] label,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] vocab_limit
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic [11:0]  vocab;
  logic         out_free;
  logic         move1;
  token_state_t tok_cur;
  token_state_t tok_upd;
  status_t      cls_status;
  logic [11:0]  cls_label;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign move1     = s1_valid && (!s1_last || out_free);
  assign in_stall  = s1_valid && !move1;

  // vocabulary register
  always_ff @(posedge clk) begin
    if (rst) begin
      vocab <= VOCAB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vocab <= vocab_limit;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= byte_value;
      s1_last <= last_byte;
    end
  end

  utd_token_state u_state (
    .clk     (clk),
    .rst     (rst),
    .step    (move1),
    .byte_in (s1_byte),
    .last_in (s1_last),
    .cur     (tok_cur),
    .upd     (tok_upd)
  );

  utd_classify u_classify (
    .tok        (tok_upd),
    .vocab      (vocab),
    .status_out (cls_status),
    .label_out  (cls_label)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move1 && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move1 && s1_last) begin
      status <= cls_status;
      label  <= cls_label;
    end
  end

  // label field is zero unless a label is reported
  a_label_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_LABEL || label == 12'd0))
    else $error("label nonzero with non-label status");

  // input side only waits behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a finished token always yields a result
  a_result_made: assert property (@(posedge clk) disable iff (rst)
    (move1 && s1_last) |=> out_valid)
    else $error("last byte produced no result");

  // token state is cleared after its last byte
  a_state_clear: assert property (@(posedge clk) disable iff (rst)
    (move1 && s1_last) |=> (tok_cur.count == 3'd0 && tok_cur.cont_ok))
    else $error("token state not cleared");

endmodule

### tb/sv/tb.sv
module tb;
  import utd_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_BYTES = 1680;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned SETTLE       = 6;

  // the three marks, first byte highest
  localparam logic [39:0] BEGIN_TAG = 40'h3c733e;
  localparam logic [39:0] END_TAG   = 40'h3c2f733e;
  localparam logic [39:0] UNK_TAG   = 40'h3c756e6b3e;

  typedef struct packed {
    status_t     st;
    logic [11:0] lab;
  } token_result_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        l;
    logic        pin;
    status_t     st;
    logic [11:0] lab;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_value = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [11:0] label;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] vocab_limit = 12'd0;

  // fixed result that rides along with a driven byte
  logic        pin_on = 1'b0;
  status_t     pin_status = ST_LABEL;
  logic [11:0] pin_label = 12'd0;

  utf8_token_id_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_value  (byte_value),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .label       (label),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .vocab_limit (vocab_limit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed tokens: marks, byte extremes, each status
  dir_row_t dir_rows [25] = '{
    '{8'h3c, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h73, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h3e, 1'b1, 1'b1, ST_BEGIN,   12'd0},
    '{8'h3c, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h2f, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h73, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h3e, 1'b1, 1'b1, ST_END,     12'd0},
    '{8'h3c, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h75, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h6e, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h6b, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h3e, 1'b1, 1'b1, ST_UNKNOWN, 12'd0},
    '{8'h00, 1'b1, 1'b1, ST_VOCAB,   12'd0},
    '{8'h64, 1'b1, 1'b1, ST_LABEL,   12'd0},
    '{8'hff, 1'b1, 1'b1, ST_BAD_LEN, 12'd0},
    '{8'he0, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h80, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h80, 1'b1, 1'b1, ST_BAD_UTF, 12'd0},
    '{8'hc2, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h41, 1'b1, 1'b0, ST_LABEL,   12'd0},
    '{8'h41, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h41, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h41, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h41, 1'b0, 1'b0, ST_LABEL,   12'd0},
    '{8'h41, 1'b1, 1'b1, ST_BAD_LEN, 12'd0}
  };

  // vocabulary per random phase, negative picks a random size
  int plan [PHASES] = '{1, 4095, 0, -1, 4094, -1, 4093};

  // decoder state mirror
  logic [11:0] mdl_vocab;
  logic [2:0]  tk_count;
  logic [7:0]  tk_lead;
  logic [20:0] tk_cp;
  logic        tk_cont_ok;
  logic        tk_begin;
  logic        tk_end;
  logic        tk_unk;

  token_result_t tokens_due [$];
  logic [7:0]    tok_bytes [$];
  int unsigned   phase_vocab = 4093;
  int unsigned   burst_left = 0;
  int            err_count = 0;

  function automatic int unsigned seq_len(input logic [7:0] b);
    if (b < 8'h80) return 1;
    if (b >= 8'hc2 && b < 8'he0) return 2;
    if (b >= 8'he0 && b < 8'hf0) return 3;
    if (b >= 8'hf0 && b <= 8'hf4) return 4;
    return 0;
  endfunction

  function automatic logic tag_hit(input logic [39:0] tag, input int unsigned len,
                                   input int unsigned pos, input logic [7:0] b);
    logic [39:0] sh;
    if (pos >= len) return 1'b0;
    sh = tag >> (8 * (len - 1 - pos));
    return sh[7:0] == b;
  endfunction

  function automatic void restart_token();
    tk_count   = 3'd0;
    tk_lead    = 8'h00;
    tk_cp      = 21'd0;
    tk_cont_ok = 1'b1;
    tk_begin   = 1'b1;
    tk_end     = 1'b1;
    tk_unk     = 1'b1;
  endfunction

  // advance the token by one byte, give the token result on its last byte
  function automatic bit decode_byte(input logic [7:0] b, input logic l,
                                     output token_result_t r);
    int unsigned pos;
    int unsigned sz;
    int unsigned len;
    pos = tk_count;
    r = '{ST_LABEL, 12'd0};
    tk_begin = tk_begin && tag_hit(BEGIN_TAG, 3, pos, b);
    tk_end   = tk_end && tag_hit(END_TAG, 4, pos, b);
    tk_unk   = tk_unk && tag_hit(UNK_TAG, 5, pos, b);
    if (pos == 0) begin
      tk_lead = b;
      case (seq_len(b))
        1: tk_cp = {14'd0, b[6:0]};
        2: tk_cp = {16'd0, b[4:0]};
        3: tk_cp = {17'd0, b[3:0]};
        4: tk_cp = {18'd0, b[2:0]};
        default: tk_cp = 21'd0;
      endcase
    end else if (pos < 4) begin
      if (b[7:6] != 2'b10) tk_cont_ok = 1'b0;
      tk_cp = {tk_cp[14:0], b[5:0]};
    end
    tk_count = (pos < 7) ? 3'(pos + 1) : 3'd7;
    if (!l) return 1'b0;

    len = tk_count;
    sz = seq_len(tk_lead);
    if (tk_begin && len == 3) r.st = ST_BEGIN;
    else if (tk_end && len == 4) r.st = ST_END;
    else if (tk_unk && len == 5) r.st = ST_UNKNOWN;
    else if (sz == 0 || len != sz) r.st = ST_BAD_LEN;
    else if (!tk_cont_ok ||
             (sz == 2 && tk_cp < 21'h80) ||
             (sz == 3 && tk_cp < 21'h800) ||
             (sz == 4 && tk_cp < 21'h10000) ||
             tk_cp > 21'h10ffff ||
             (tk_cp >= 21'hd800 && tk_cp <= 21'hdfff)) r.st = ST_BAD_UTF;
    else if (tk_cp < 100 || (tk_cp - 100) >= mdl_vocab) r.st = ST_VOCAB;
    else begin
      r.st = ST_LABEL;
      r.lab = 12'(tk_cp - 100);
    end
    restart_token();
    return 1'b1;
  endfunction

  // predict accepted bytes, check accepted results
  always @(posedge clk) begin : monitor
    token_result_t next_r;
    token_result_t want;
    if (rst) begin
      mdl_vocab = 12'd4093;
      restart_token();
      tokens_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) mdl_vocab = vocab_limit;
      if (in_valid && !in_stall) begin
        if (decode_byte(byte_value, last_byte, next_r)) begin
          if (pin_on) begin
            next_r.st = pin_status;
            next_r.lab = pin_label;
          end
          tokens_due.insert(tokens_due.size(), next_r);
        end
      end
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: status %0d label %0d", status, label);
        end else begin
          want = tokens_due.pop_front();
          if (status != want.st || label != want.lab) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: status %0d label %0d, expected status %0d label %0d",
                       status, label, want.st, want.lab);
          end
        end
      end
    end
  end

  // receiver stall pattern, in spans of differing density
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  always @(posedge clk) begin : receiver
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(10, 60);
    end
    stall_span--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 4);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ~out_stall;
    endcase
  end

  // watchdog on cycles without any handshake
  int unsigned quiet = 0;
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one byte, with a random gap whenever a burst runs out
  task automatic send_byte(input logic [7:0] b, input logic l, input logic pin,
                           input status_t st, input logic [11:0] lab);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    byte_value <= b;
    last_byte  <= l;
    pin_on     <= pin;
    pin_status <= st;
    pin_label  <= lab;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_token();
    foreach (tok_bytes[k])
      send_byte(tok_bytes[k], k == tok_bytes.size() - 1, 1'b0, ST_LABEL, 12'd0);
  endtask

  // wait for every pending result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tokens_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_vocab(input logic [11:0] v);
    drain();
    cfg_valid   <= 1'b1;
    vocab_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    phase_vocab = v;
  endtask

  function automatic int unsigned min_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // append one byte to the token
  function automatic void add_byte(input logic [7:0] b);
    tok_bytes.insert(tok_bytes.size(), b);
  endfunction

  function automatic void push_utf8(input logic [20:0] cp, input int unsigned n);
    case (n)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // one random token, well formed or malformed
  function automatic void build_token();
    int unsigned kind;
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    int unsigned tag_len;
    logic [20:0] cp;
    logic [39:0] tag;
    tok_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // shortest-form code points, many near the vocabulary edges
      pick = $urandom_range(0, 5);
      case (pick)
        0: cp = 21'(100 + $urandom_range(0, phase_vocab));
        1: cp = 21'(99 + phase_vocab + $urandom_range(0, 1));
        2: cp = 21'($urandom_range(0, 127));
        3: cp = 21'($urandom_range(0, 21'h10ffff));
        4: cp = 21'($urandom_range(21'hd700, 21'he100));
        default: cp = 21'($urandom_range(100, 4300));
      endcase
      push_utf8(cp, min_len(cp));
    end else if (kind < 58) begin
      // forms that may be overlong, and values up to and past the top code point
      if ($urandom_range(0, 1) == 0) begin
        cp = 21'($urandom_range(0, 21'hffff));
        push_utf8(cp, $urandom_range(min_len(cp), 4));
      end else begin
        cp = 21'($urandom_range(21'h10f000, 21'h1fffff));
        push_utf8(cp, 4);
      end
    end else if (kind < 70) begin
      // marks, exact or slightly off
      pick = $urandom_range(0, 2);
      tag = (pick == 0) ? BEGIN_TAG : (pick == 1) ? END_TAG : UNK_TAG;
      tag_len = pick + 3;
      for (k = 0; k < tag_len; k++)
        add_byte(8'(tag >> (8 * (tag_len - 1 - k))));
      case ($urandom_range(0, 4))
        0: tok_bytes.delete(tok_bytes.size() - 1);
        1: add_byte(8'($urandom_range(0, 255)));
        2: tok_bytes[$urandom_range(0, tag_len - 1)] = 8'($urandom_range(0, 255));
        default: ;
      endcase
    end else if (kind < 80) begin
      // one continuation byte spoiled
      cp = 21'($urandom_range(21'h80, 21'h10ffff));
      push_utf8(cp, min_len(cp));
      k = $urandom_range(1, tok_bytes.size() - 1);
      tok_bytes[k] = tok_bytes[k] ^ (8'h40 << $urandom_range(0, 1));
    end else if (kind < 90) begin
      // cut short or run on, some past the counter saturation
      cp = 21'($urandom_range(0, 21'h10ffff));
      push_utf8(cp, min_len(cp));
      if (tok_bytes.size() > 1 && $urandom_range(0, 1) == 0) begin
        tok_bytes.delete(tok_bytes.size() - 1);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) add_byte(8'($urandom_range(128, 191)));
      end
    end else begin
      // raw noise
      n = $urandom_range(1, 9);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin : stimulus
    int unsigned sent;
    logic [11:0] v;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].pin, dir_rows[i].st, dir_rows[i].lab);

    foreach (plan[p]) begin
      v = (plan[p] < 0) ? 12'($urandom_range(2, 4092)) : 12'(plan[p]);
      set_vocab(v);
      sent = 0;
      while (sent < RANDOM_BYTES / PHASES) begin
        build_token();
        sent += tok_bytes.size();
        send_token();
      end
    end

    drain();
    if (err_count == 0 && tokens_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/utd_pkg.sv
rtl/core/utd_token_state.sv
rtl/core/utd_classify.sv
rtl/core/utd_token_id_decoder.sv
tb/sv/tb.sv
